// ----- src/skr_pkg.sv -----
`timescale 1ns / 1ps
// types and constants shared by the skyline packer modules
// no dependencies
package skr_pkg;

    localparam int unsigned DIM_W   = 14;
    localparam int unsigned RECT_W  = 13;
    localparam int unsigned PAD_W   = 4;
    localparam logic [DIM_W-1:0] ATLAS_LIMIT = 14'd8192;

    typedef enum logic [2:0] {
        STS_PLACED  = 3'd0,
        STS_EMPTY   = 3'd1,
        STS_NOROOM  = 3'd2,
        STS_FULL    = 3'd3,
        STS_CLEARED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_ATLAS_WIDTH  = 2'd0,
        REG_ATLAS_HEIGHT = 2'd1,
        REG_PADDING      = 2'd2
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_RD_I, ST_EV_I, ST_RD_J, ST_EV_J, ST_CAND, ST_FIN,
        ST_CP_RD, ST_CP_WR, ST_WR_B, ST_WR_E, ST_CLR, ST_RES
    } state_t;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
    } node_t;

    typedef struct packed {
        logic [DIM_W-1:0] aw;
        logic [DIM_W-1:0] ah;
        logic [PAD_W-1:0] pad;
    } cfg_t;

    typedef struct packed {
        status_t           status;
        logic [RECT_W-1:0] x;
        logic [RECT_W-1:0] y;
    } res_t;

endpackage

// ----- src/skr_node_mem.sv -----
`timescale 1ns / 1ps
// skyline node memory, one access per cycle, registered read data
// depends on skr_pkg
module skr_node_mem
    import skr_pkg::*;
#(
    parameter int unsigned DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  node_t                    wdata,
    output node_t                    rdata
);

    node_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- src/skr_engine.sv -----
`timescale 1ns / 1ps
// placement sequencer: best-fit scan over the node memory and in-place rewrite
// depends on skr_pkg and skr_node_mem
module skr_engine
    import skr_pkg::*;
#(
    parameter int unsigned MAX_NODES = 512
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    input  logic [RECT_W-1:0] in_w,
    input  logic [RECT_W-1:0] in_h,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res
);

    localparam int unsigned AW = $clog2(MAX_NODES);
    localparam int unsigned CW = $clog2(MAX_NODES + 1);

    state_t state_reg, state_next;

    logic [RECT_W-1:0] w_reg, w_next, h_reg, h_next;
    logic [CW-1:0]     cnt_reg, cnt_next, i_reg, i_next, j_reg, j_next;
    logic [CW-1:0]     e_reg, e_next, bi_reg, bi_next, be_reg, be_next;
    logic [CW-1:0]     k_reg, k_next, dst_reg, dst_next;
    logic [CW:0]       tot_reg, tot_next;
    logic [DIM_W-1:0]  cx_reg, cx_next, top_reg, top_next, lasty_reg, lasty_next;
    logic [DIM_W-1:0]  bx_reg, bx_next, by_reg, by_next, bfloor_reg, bfloor_next;
    logic [DIM_W:0]    right_reg, right_next;
    logic              at_end_reg, at_end_next, found_reg, found_next;
    logic              bat_reg, bat_next, bwd_reg, bwd_next;
    res_t              res_reg, res_next;

    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;
    node_t             mem_wdata, rd;

    logic [DIM_W:0]    right_calc, fit_calc, end_x, shelf;
    logic [CW:0]       total;
    logic [CW-1:0]     d0;
    logic              better;

    skr_node_mem #(.DEPTH(MAX_NODES)) u_mem (
        .aclk  (aclk),
        .wr_en (mem_we),
        .rd_en (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rd)
    );

    assign right_calc = {1'b0, rd.x} + (DIM_W+1)'(w_reg) + (DIM_W+1)'(cfg.pad);
    assign fit_calc   = {1'b0, top_reg} + (DIM_W+1)'(h_reg) + (DIM_W+1)'(cfg.pad);
    assign better     = (fit_calc <= {1'b0, cfg.ah}) && (!found_reg || top_reg < by_reg);
    assign end_x      = {1'b0, bx_reg} + (DIM_W+1)'(w_reg) + (DIM_W+1)'(cfg.pad);
    assign shelf      = {1'b0, by_reg} + (DIM_W+1)'(h_reg) + (DIM_W+1)'(cfg.pad);
    assign d0         = bi_reg + CW'(1) + CW'(!bat_reg);
    assign total      = {1'b0, d0} + ({1'b0, cnt_reg} - {1'b0, be_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            cnt_reg   <= CW'(1);
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        w_reg <= w_next;  h_reg <= h_next;  i_reg <= i_next;  j_reg <= j_next;
        e_reg <= e_next;  bi_reg <= bi_next;  be_reg <= be_next;
        k_reg <= k_next;  dst_reg <= dst_next;  tot_reg <= tot_next;
        cx_reg <= cx_next;  top_reg <= top_next;  lasty_reg <= lasty_next;
        bx_reg <= bx_next;  by_reg <= by_next;  bfloor_reg <= bfloor_next;
        right_reg <= right_next;  at_end_reg <= at_end_next;
        found_reg <= found_next;  bat_reg <= bat_next;  bwd_reg <= bwd_next;
        res_reg <= res_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_op)                          state_next = ST_CLR;
                    else if (in_w == '0 || in_h == '0)  state_next = ST_RES;
                    else                                state_next = ST_RD_I;
                end
            end
            ST_RD_I: state_next = ST_EV_I;
            ST_EV_I: begin
                if (right_calc > {1'b0, cfg.aw})
                    state_next = (i_reg + CW'(1) == cnt_reg) ? ST_FIN : ST_RD_I;
                else
                    state_next = ST_RD_J;
            end
            ST_RD_J: state_next = ST_EV_J;
            ST_EV_J: begin
                if ({1'b0, rd.x} < right_reg)
                    state_next = (j_reg + CW'(1) == cnt_reg) ? ST_CAND : ST_RD_J;
                else
                    state_next = ST_CAND;
            end
            ST_CAND: state_next = (i_reg + CW'(1) == cnt_reg) ? ST_FIN : ST_RD_I;
            ST_FIN: begin
                if (!found_reg || total > (CW+1)'(MAX_NODES)) state_next = ST_RES;
                else if (be_reg == cnt_reg || d0 == be_reg)   state_next = ST_WR_B;
                else                                          state_next = ST_CP_RD;
            end
            ST_CP_RD: state_next = ST_CP_WR;
            ST_CP_WR: begin
                if (bwd_reg ? (k_reg == be_reg) : (k_reg + CW'(1) == cnt_reg))
                    state_next = ST_WR_B;
                else
                    state_next = ST_CP_RD;
            end
            ST_WR_B: state_next = bat_reg ? ST_RES : ST_WR_E;
            ST_WR_E: state_next = ST_RES;
            ST_CLR:  state_next = ST_RES;
            ST_RES:  state_next = res_ready ? ST_IDLE : ST_RES;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        w_next = w_reg;  h_next = h_reg;  cnt_next = cnt_reg;
        i_next = i_reg;  j_next = j_reg;  e_next = e_reg;
        bi_next = bi_reg;  be_next = be_reg;  k_next = k_reg;
        dst_next = dst_reg;  tot_next = tot_reg;  cx_next = cx_reg;
        top_next = top_reg;  lasty_next = lasty_reg;  bx_next = bx_reg;
        by_next = by_reg;  bfloor_next = bfloor_reg;  right_next = right_reg;
        at_end_next = at_end_reg;  found_next = found_reg;
        bat_next = bat_reg;  bwd_next = bwd_reg;  res_next = res_reg;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        case (state_reg)
            ST_INIT: mem_we = 1'b1;
            ST_IDLE: begin
                in_ready = 1'b1;
                w_next = in_w;
                h_next = in_h;
                i_next = '0;
                found_next = 1'b0;
                res_next = '{status: STS_EMPTY, x: '0, y: '0};
            end
            ST_RD_I: begin
                mem_re = 1'b1;
                mem_addr = i_reg[AW-1:0];
            end
            ST_EV_I: begin
                cx_next = rd.x;
                right_next = right_calc;
                j_next = i_reg;
                top_next = '0;
                if (right_calc > {1'b0, cfg.aw}) i_next = i_reg + CW'(1);
            end
            ST_RD_J: begin
                mem_re = 1'b1;
                mem_addr = j_reg[AW-1:0];
            end
            ST_EV_J: begin
                if ({1'b0, rd.x} < right_reg) begin
                    if (rd.y > top_reg) top_next = rd.y;
                    lasty_next = rd.y;
                    j_next = j_reg + CW'(1);
                    e_next = cnt_reg;
                    at_end_next = 1'b0;
                end else begin
                    e_next = j_reg;
                    at_end_next = ({1'b0, rd.x} == right_reg);
                end
            end
            ST_CAND: begin
                if (better) begin
                    found_next = 1'b1;
                    by_next = top_reg;
                    bx_next = cx_reg;
                    bi_next = i_reg;
                    be_next = e_reg;
                    bat_next = at_end_reg;
                    bfloor_next = lasty_reg;
                end
                i_next = i_reg + CW'(1);
            end
            ST_FIN: begin
                tot_next = total;
                bwd_next = d0 > be_reg;
                if (d0 > be_reg) begin
                    k_next = cnt_reg - CW'(1);
                    dst_next = cnt_reg;
                end else begin
                    k_next = be_reg;
                    dst_next = d0;
                end
                if (!found_reg)
                    res_next = '{status: STS_NOROOM, x: '0, y: '0};
                else if (total > (CW+1)'(MAX_NODES))
                    res_next = '{status: STS_FULL, x: '0, y: '0};
                else
                    res_next = '{status: STS_PLACED, x: bx_reg[RECT_W-1:0],
                                 y: by_reg[RECT_W-1:0]};
            end
            ST_CP_RD: begin
                mem_re = 1'b1;
                mem_addr = k_reg[AW-1:0];
            end
            ST_CP_WR: begin
                mem_we = 1'b1;
                mem_addr = dst_reg[AW-1:0];
                mem_wdata = rd;
                if (bwd_reg) begin
                    k_next = k_reg - CW'(1);
                    dst_next = dst_reg - CW'(1);
                end else begin
                    k_next = k_reg + CW'(1);
                    dst_next = dst_reg + CW'(1);
                end
            end
            ST_WR_B: begin
                mem_we = 1'b1;
                mem_addr = bi_reg[AW-1:0];
                mem_wdata = '{x: bx_reg, y: shelf[DIM_W-1:0]};
                cnt_next = tot_reg[CW-1:0];
            end
            ST_WR_E: begin
                mem_we = 1'b1;
                mem_addr = AW'(bi_reg + CW'(1));
                mem_wdata = '{x: end_x[DIM_W-1:0], y: bfloor_reg};
            end
            ST_CLR: begin
                mem_we = 1'b1;
                cnt_next = CW'(1);
                res_next = '{status: STS_CLEARED, x: '0, y: '0};
            end
            ST_RES: res_valid = 1'b1;
            default: ;
        endcase
    end

    assign res = res_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != '0 && {1'b0, cnt_reg} <= (CW+1)'(MAX_NODES))
        else $error("node count out of range");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLR |=> cnt_reg == CW'(1))
        else $error("clear did not reset node count");

    a_fwd_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CP_WR && !bwd_reg) |-> dst_reg < k_reg)
        else $error("forward copy overtakes its source");

    a_bwd_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CP_WR && bwd_reg) |-> dst_reg == k_reg + CW'(1))
        else $error("backward copy offset wrong");

endmodule

// ----- src/skr_out_reg.sv -----
`timescale 1ns / 1ps
// result output register, frees the sequencer while the receiver stalls
// depends on skr_pkg
module skr_out_reg
    import skr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_res,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic valid_reg, valid_next;
    res_t res_reg, res_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) res_next = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ----- src/skyline_rectangle_packer.sv -----
`timescale 1ns / 1ps
// Skyline rectangle packer, top level.
// Input stream: s_tuser is the opcode (place or clear), s_tdata carries the
// rectangle width and height. Result stream: one item per input item, m_tuser
// is the status, m_tdata the placed x and y (zero unless placed).
// Configuration: cfg_wr_en / cfg_index / cfg_wdata write atlas width, atlas
// height and padding; write only while the block is idle.
// Sequence: the skyline lives in one node memory with registered read data.
// An empty rectangle goes straight to the result; a clear resets the skyline first.
// A placement reads every node i and, for each node whose span fits the width,
// the nodes under the span, at most N*(N+1)/2 inner reads for N nodes;
// then it decides, shifts the following nodes by a read and a write each,
// writes 1 or 2 nodes and hands the result on to the output register;
// no room or skyline full skips the rewrite. One item is processed at a time;
// s_tready is high only when idle, from the cycle after the result is handed on.
// Reset: the skyline is one node at the origin; the init state writes the
// first entry and then the block becomes ready. Registers return to
// 512 x 512 with padding 2.
// Stall: a result waits in the output register while the next item is
// already taken; a second result waits inside the sequencer until free.
// depends on skr_pkg, skr_engine, skr_out_reg
module skyline_rectangle_packer
    import skr_pkg::*;
#(
    parameter int unsigned MAX_NODES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rect_width[12:0], rect_height[25:13]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // place_x[12:0], place_y[25:13]
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_wdata
);

    cfg_t cfg_reg, cfg_next;
    logic [DIM_W-1:0] dim_clamped;
    logic res_valid, res_ready;
    res_t res, out_res;

    assign dim_clamped = (cfg_wdata > ATLAS_LIMIT) ? ATLAS_LIMIT : cfg_wdata;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ATLAS_WIDTH:  cfg_next.aw  = dim_clamped;
                REG_ATLAS_HEIGHT: cfg_next.ah  = dim_clamped;
                REG_PADDING:      cfg_next.pad = cfg_wdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{aw: 14'd512, ah: 14'd512, pad: 4'd2};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    skr_engine #(.MAX_NODES(MAX_NODES)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_w      (s_tdata[12:0]),
        .in_h      (s_tdata[25:13]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    skr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = {6'd0, out_res.y, out_res.x};

endmodule

// ----- tb/sv/skyline_rectangle_packer_tb.sv -----
`timescale 1ns / 1ps
// testbench for the skyline rectangle packer: directed and random place and clear items,
// checked against a behavioural skyline predictor held in a small scoreboard class
// depends on skr_pkg and skyline_rectangle_packer
module skyline_rectangle_packer_tb;
    import skr_pkg::*;

    localparam int NODE_LIMIT = 512;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct {
        status_t    status;
        logic [12:0] x;
        logic [12:0] y;
    } placement_t;

    int mismatch_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    class packer_scoreboard;
        int unsigned sky_x[$];
        int unsigned sky_y[$];
        int unsigned aw = 512, ah = 512, pad = 2;
        placement_t pending[$];

        function void set_reg(reg_index_t idx, int unsigned v);
            case (idx)
                REG_ATLAS_WIDTH:  aw = v & 16'h3fff;
                REG_ATLAS_HEIGHT: ah = v & 16'h3fff;
                REG_PADDING:      pad = v & 4'hf;
                default: ;
            endcase
        endfunction

        function void reset_sky();
            sky_x = {0};
            sky_y = {0};
        endfunction

        function void note_item(bit op, int unsigned w, int unsigned h);
            placement_t r;
            int unsigned cw, ch, right, top, bx, by, ex, floor_y, n;
            bit found, at_end;
            int unsigned nx[$];
            int unsigned ny[$];
            r.status = STS_PLACED;
            r.x = 0;
            r.y = 0;
            found = 0;
            bx = 0;
            by = 0;
            cw = (aw > 8192) ? 8192 : aw;
            ch = (ah > 8192) ? 8192 : ah;
            if (op) begin
                reset_sky();
                r.status = STS_CLEARED;
            end else if (w == 0 || h == 0) begin
                r.status = STS_EMPTY;
            end else begin
                for (int i = 0; i < sky_x.size(); i++) begin
                    right = sky_x[i] + w + pad;
                    if (right > cw) continue;
                    top = sky_y[i];
                    for (int j = i; j < sky_x.size() && sky_x[j] < right; j++)
                        if (sky_y[j] > top) top = sky_y[j];
                    if (top + h + pad <= ch && (!found || top < by)) begin
                        found = 1;
                        by = top;
                        bx = sky_x[i];
                    end
                end
                if (!found) begin
                    r.status = STS_NOROOM;
                end else begin
                    ex = bx + w + pad;
                    floor_y = 0;
                    at_end = 0;
                    foreach (sky_x[i]) begin
                        if (sky_x[i] < ex) floor_y = sky_y[i];
                        if (sky_x[i] == ex) at_end = 1;
                    end
                    foreach (sky_x[i]) if (sky_x[i] < bx) begin
                        nx.push_back(sky_x[i]);
                        ny.push_back(sky_y[i]);
                    end
                    nx.push_back(bx);
                    ny.push_back(by + h + pad);
                    if (!at_end) begin
                        nx.push_back(ex);
                        ny.push_back(floor_y);
                    end
                    foreach (sky_x[i]) if (sky_x[i] >= ex) begin
                        nx.push_back(sky_x[i]);
                        ny.push_back(sky_y[i]);
                    end
                    n = nx.size();
                    if (n > NODE_LIMIT) begin
                        r.status = STS_FULL;
                    end else begin
                        sky_x = nx;
                        sky_y = ny;
                        r.x = bx[12:0];
                        r.y = by[12:0];
                    end
                end
            end
            pending.push_back(r);
        endfunction

        task check_result(logic [2:0] st, logic [12:0] x, logic [12:0] y);
            placement_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected item status", st, -1);
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) report_mismatch("status", st, e.status);
            if (x !== e.x) report_mismatch("place_x", x, e.x);
            if (y !== e.y) report_mismatch("place_y", y, e.y);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = '0;
    logic [13:0] cfg_wdata = '0;

    packer_scoreboard sb = new();
    bit calm = 0;
    longint cycles = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    skyline_rectangle_packer i_dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** skyline_rectangle_packer: FAILED **");
            $finish;
        end
    end

    // result side: values are stable mid-cycle, the item is taken at the next edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[12:0], m_tdata[25:13]);
    end

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
    end

    task automatic send_item(input bit op, input int unsigned w, input int unsigned h);
        bit rdy;
        if (!calm && $urandom_range(99) < 13) begin
            s_tvalid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < 13) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {6'd0, h[12:0], w[12:0]};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        sb.note_item(op, w, h);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input int unsigned v);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v[13:0];
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic set_atlas(input int unsigned w, input int unsigned h, input int unsigned p);
        drain();
        write_reg(REG_ATLAS_WIDTH, w);
        write_reg(REG_ATLAS_HEIGHT, h);
        write_reg(REG_PADDING, p);
        cfg_wr_en <= 0;
    endtask

    task automatic random_rects(input int count, input int unsigned maxdim);
        int unsigned k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            if (k < 4) send_item(1, $urandom_range(8191), $urandom_range(8191));
            else if (k < 8) send_item(0, $urandom_range(1) ? 0 : $urandom_range(8191),
                                      $urandom_range(1) ? $urandom_range(8191) : 0);
            else if (k < 12) send_item(0, $urandom_range(8191), $urandom_range(8191));
            else send_item(0, $urandom_range(maxdim, 1), $urandom_range(maxdim, 1));
        end
    endtask

    initial begin
        sb.reset_sky();
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed
        send_item(0, 0, 5);
        send_item(0, 5, 0);
        send_item(0, 10, 10);
        send_item(0, 10, 20);
        send_item(0, 8191, 8191);
        send_item(0, 510, 3);
        send_item(0, 1, 1);
        send_item(1, 8191, 8191);
        send_item(0, 498, 4);
        send_item(0, 100, 100);
        set_atlas(16383, 16383, 15);
        send_item(0, 8191, 8191);
        send_item(0, 8191, 100);
        send_item(0, 4000, 8000);
        set_atlas(1, 1, 0);
        send_item(0, 1, 1);
        send_item(0, 1, 1);
        send_item(1, 0, 0);
        send_item(0, 1, 1);
        set_atlas(8192, 8192, 0);
        send_item(0, 4096, 10);
        send_item(0, 4096, 5);
        send_item(0, 1, 1);
        // node count growth towards the limit with unit widths
        set_atlas(1200, 8192, 0);
        send_item(1, 0, 0);
        for (int i = 0; i < 300; i++) send_item(0, 1, (i % 2) ? 1 : 2);
        drain();
        calm = 1;
        random_rects(150, 40);
        calm = 0;
        set_atlas(512, 512, 2);
        random_rects(250, 64);
        set_atlas($urandom_range(200, 1), $urandom_range(200, 1), $urandom_range(15));
        random_rects(200, 30);
        set_atlas(8192, 300, 15);
        random_rects(220, 200);
        set_atlas($urandom_range(16383), $urandom_range(16383), $urandom_range(15));
        random_rects(100, 8191);
        drain();
        if (mismatch_count == 0 && sb.pending.size() == 0) begin
            $display("** skyline_rectangle_packer: PASSED **");
        end else begin
            $display("** skyline_rectangle_packer: FAILED **");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/skr_pkg.sv
src/skr_node_mem.sv
src/skr_engine.sv
src/skr_out_reg.sv
src/skyline_rectangle_packer.sv
tb/sv/skyline_rectangle_packer_tb.sv
